// ===== src/rbpfw_pkg.sv =====
// Shared constants, register codes and helpers for the rectangle blit pixel writer.
package rbpfw_pkg;

    localparam int DIM_W      = 13;
    localparam int STRIDE_W   = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int COORD_W    = 15;
    localparam int ADDR_W     = 26;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 3;
    localparam int CHAN_W     = 8;

    localparam int unsigned MAX_DIM = 4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_PIXEL_FORMAT  = 3'd2,
        REG_ROW_STRIDE    = 3'd3,
        REG_RECT_LEFT     = 3'd4,
        REG_RECT_TOP      = 3'd5,
        REG_RECT_COLS     = 3'd6,
        REG_RECT_ROWS     = 3'd7
    } cfg_reg_t;

    localparam logic [1:0] FMT_BGRA8888 = 2'd0;
    localparam logic [1:0] FMT_BGR888   = 2'd1;
    localparam logic [1:0] FMT_RGB565   = 2'd2;

    localparam logic [COUNT_W-1:0] BYTES_BGRA8888 = 3'd4;
    localparam logic [COUNT_W-1:0] BYTES_BGR888   = 3'd3;
    localparam logic [COUNT_W-1:0] BYTES_RGB565   = 3'd2;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(MAX_DIM);
        return (v > lim) ? lim : v;
    endfunction

endpackage

// ===== src/rect_blit_pixel_format_writer.sv =====
// Rectangle blit writer: walks a source rectangle and emits packed framebuffer writes.
//
//  Channel  Direction  Handshake              Payload
//  in       sink       in_valid / in_stall    red, green, blue, alpha, final_pixel
//  out      source     out_valid / out_stall  byte_addr, write_data, byte_count
//  cfg      sink       cfg_wr_en              cfg_index, cfg_wr_data
//
// One source pixel is accepted every cycle while in_stall is low.
// The rate is set by the two-stage pipe: position stage, then address multiply and packing.
// Reset clears the configuration registers, the source counters and both valid flags.
// A stall on the output holds the result register and backs up into the input stall
// once the position stage is also full.
module rect_blit_pixel_format_writer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [rbpfw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rbpfw_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [rbpfw_pkg::CHAN_W-1:0]          red,
    input  logic [rbpfw_pkg::CHAN_W-1:0]          green,
    input  logic [rbpfw_pkg::CHAN_W-1:0]          blue,
    input  logic [rbpfw_pkg::CHAN_W-1:0]          alpha,
    input  logic                                  final_pixel,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [rbpfw_pkg::ADDR_W-1:0]          byte_addr,
    output logic [rbpfw_pkg::DATA_W-1:0]          write_data,
    output logic [rbpfw_pkg::COUNT_W-1:0]         byte_count
);
    import rbpfw_pkg::*;

    logic [DIM_W-1:0]     screen_width_reg;
    logic [DIM_W-1:0]     screen_height_reg;
    logic [1:0]           pixel_format_reg;
    logic [STRIDE_W-1:0]  row_stride_reg;
    logic [DIM_W-1:0]     rect_left_reg;
    logic [DIM_W-1:0]     rect_top_reg;
    logic [DIM_W-1:0]     rect_cols_reg;
    logic [DIM_W-1:0]     rect_rows_reg;

    logic [DIM_W-1:0]     src_col_reg;
    logic [DIM_W-1:0]     src_row_reg;
    logic [DIM_W-1:0]     src_col_next;
    logic [DIM_W-1:0]     src_row_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [COORD_W-1:0]   x_reg;
    logic [COORD_W-1:0]   y_reg;
    logic [CHAN_W-1:0]    red_reg;
    logic [CHAN_W-1:0]    green_reg;
    logic [CHAN_W-1:0]    blue_reg;
    logic [CHAN_W-1:0]    alpha_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ADDR_W-1:0]    byte_addr_reg;
    logic [DATA_W-1:0]    write_data_reg;
    logic [COUNT_W-1:0]   byte_count_reg;

    logic                 out_ready;
    logic                 s1_ready;
    logic                 in_accept;
    logic                 in_rect;
    logic [DIM_W:0]       col_inc;
    logic [COORD_W-1:0]   x_next;
    logic [COORD_W-1:0]   y_next;

    logic [DIM_W-1:0]     width_lim;
    logic [DIM_W-1:0]     height_lim;
    logic                 on_screen;
    logic                 fmt_ok;
    logic [COUNT_W-1:0]   bytes_sel;
    logic [DATA_W-1:0]    data_sel;
    logic [26:0]          row_off;
    logic [14:0]          col_off;
    logic [ADDR_W-1:0]    addr_sel;
    logic                 hit;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
            pixel_format_reg  <= '0;
            row_stride_reg    <= '0;
            rect_left_reg     <= '0;
            rect_top_reg      <= '0;
            rect_cols_reg     <= '0;
            rect_rows_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wr_data[DIM_W-1:0];
                REG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_wr_data[1:0];
                REG_ROW_STRIDE:    row_stride_reg    <= cfg_wr_data[STRIDE_W-1:0];
                REG_RECT_LEFT:     rect_left_reg     <= cfg_wr_data[DIM_W-1:0];
                REG_RECT_TOP:      rect_top_reg      <= cfg_wr_data[DIM_W-1:0];
                REG_RECT_COLS:     rect_cols_reg     <= cfg_wr_data[DIM_W-1:0];
                REG_RECT_ROWS:     rect_rows_reg     <= cfg_wr_data[DIM_W-1:0];
                default:           rect_rows_reg     <= rect_rows_reg;
            endcase
        end
    end

    // Source position counters and the screen position of the incoming pixel.
    always_comb
    begin
        in_rect      = (src_col_reg < rect_cols_reg) && (src_row_reg < rect_rows_reg);
        col_inc      = {1'b0, src_col_reg} + (DIM_W+1)'(1);
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        x_next = COORD_W'($signed(rect_left_reg)) + COORD_W'(src_col_reg);
        y_next = COORD_W'($signed(rect_top_reg)) + COORD_W'(src_row_reg);
        if (in_accept)
        begin
            if (in_rect)
            begin
                if (col_inc >= {1'b0, rect_cols_reg})
                begin
                    src_col_next = '0;
                    src_row_next = src_row_reg + DIM_W'(1);
                end
                else
                begin
                    src_col_next = col_inc[DIM_W-1:0];
                end
            end
            if (final_pixel)
            begin
                src_col_next = '0;
                src_row_next = '0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = in_accept && in_rect;
        end
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = s1_valid_reg && hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg   <= '0;
            src_row_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            src_col_reg   <= src_col_next;
            src_row_reg   <= src_row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
        end
    end

    // Clipping, pixel packing and address generation.
    always_comb
    begin
        width_lim  = clamp_dim(screen_width_reg);
        height_lim = clamp_dim(screen_height_reg);
        on_screen  = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                  && (x_reg[COORD_W-2:0] < {1'b0, width_lim})
                  && (y_reg[COORD_W-2:0] < {1'b0, height_lim});
        fmt_ok     = 1'b1;
        bytes_sel  = BYTES_BGRA8888;
        data_sel   = {alpha_reg, red_reg, green_reg, blue_reg};
        unique case (pixel_format_reg)
            FMT_BGRA8888:
            begin
                bytes_sel = BYTES_BGRA8888;
                data_sel  = {alpha_reg, red_reg, green_reg, blue_reg};
            end
            FMT_BGR888:
            begin
                bytes_sel = BYTES_BGR888;
                data_sel  = {8'h00, red_reg, green_reg, blue_reg};
            end
            FMT_RGB565:
            begin
                bytes_sel = BYTES_RGB565;
                data_sel  = {16'h0000, red_reg[7:3], green_reg[7:2], blue_reg[7:3]};
            end
            default:
            begin
                fmt_ok = 1'b0;
            end
        endcase
        row_off  = 27'(y_reg[11:0]) * 27'(row_stride_reg);
        col_off  = 15'(x_reg[11:0]) * 15'(bytes_sel);
        addr_sel = ADDR_W'(row_off + 27'(col_off));
        hit      = on_screen && fmt_ok;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            byte_addr_reg  <= addr_sel;
            write_data_reg <= data_sel;
            byte_count_reg <= bytes_sel;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_addr  = byte_addr_reg;
    assign write_data = write_data_reg;
    assign byte_count = byte_count_reg;

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count == BYTES_BGRA8888 || byte_count == BYTES_BGR888
                       || byte_count == BYTES_RGB565))
        else $error("Write request carries an illegal byte count.");

    a_rgb565_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == BYTES_RGB565) |-> (write_data[31:16] == 16'h0000))
        else $error("RGB565 write request has nonzero upper bytes.");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_pixel) |=> (src_col_reg == '0 && src_row_reg == '0))
        else $error("Source counters did not clear after the final pixel.");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_ready) |=> s1_valid_reg)
        else $error("Pending pixel was lost while the output was stalled.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("Input stalled while the pipeline had room.");

endmodule
